// ----- rtl/bffa_pkg.sv -----
package bffa_pkg;

  // Map geometry
  localparam int MAP_BITS       = 8192;
  localparam int SCAN_WORD_BITS = 32;
  localparam int BIT_W          = $clog2(MAP_BITS);
  localparam int WORD_W         = $clog2(SCAN_WORD_BITS);
  localparam int ROW_W          = BIT_W - WORD_W;
  localparam int MAP_ROWS       = MAP_BITS / SCAN_WORD_BITS;
  // Both maps share one memory; the top address bit selects the map.
  localparam int ADDR_W         = ROW_W + 1;
  localparam int MEM_ROWS       = 2 * MAP_ROWS;

  // Field and register widths
  localparam int NUM_W     = 14;
  localparam int CAP_W     = 14;
  localparam int START_W   = 13;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = ((NUM_W + 7) / 8) * 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = ((2 * NUM_W + ST_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [CAP_W-1:0]   CAP_RESET         = 14'd8192;
  localparam logic [START_W-1:0] BLOCK_START_RESET = 13'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INODE_CAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_START = 2'd2;

  // Request codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_FREE    = 1'b1;
  localparam logic KIND_INODE = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_CLEAR = 2'd3
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } ram_req_t;

endpackage

// ----- rtl/bffa_map_ram.sv -----
module bffa_map_ram
  import bffa_pkg::*;
(
  input  logic                      clk,
  input  ram_req_t                  req,
  input  logic [SCAN_WORD_BITS-1:0] wr_data,
  output logic [SCAN_WORD_BITS-1:0] rd_data
);

  logic [SCAN_WORD_BITS-1:0] mem_r [MEM_ROWS];
  logic [SCAN_WORD_BITS-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

// ----- rtl/bitmap_first_free_allocator.sv -----
// Sequence: an accepted allocate passes S_FETCH, then S_SCAN once per 32-bit map word scanned
//   (1 to 256), then S_RESP, which loads the output register; a free passes S_FETCH, S_FREE
//   and S_RESP; a rejected request goes straight to S_RESP. Throughput: one item at a time;
//   in_tready is high only while idle. The single map read port scans one word a cycle, and
//   an item stays longer while a result waits for out_tready.
// Reset: synchronous, active low; counts zero, capacities 8192, block search start 10.
//   A clearing pass then writes zero to all 512 map words, with in_tready held low.
module bitmap_first_free_allocator
  import bffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [13:0] number, zero padded to 16 bits
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] op, [1] kind
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [13:0] allocated_number, [15:14] status,
                                            // [29:16] free_count, zero padded to 32 bits
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CAP_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_FREE,
    S_RESP
  } state_t;

  function automatic logic [CAP_W-1:0] clamp_cap(logic [CAP_W-1:0] c);
    return (c > CAP_W'(MAP_BITS)) ? CAP_W'(MAP_BITS) : c;
  endfunction

  // Lowest clear bit of a word.
  function automatic logic [WORD_W-1:0] first_zero(logic [SCAN_WORD_BITS-1:0] w);
    logic [WORD_W-1:0] p;
    p = '0;
    for (int j = SCAN_WORD_BITS - 1; j >= 0; j--) begin
      if (!w[j]) p = WORD_W'(j);
    end
    return p;
  endfunction

  // Configuration and counts
  logic [CAP_W-1:0]   icap_r, icap_nxt;
  logic [CAP_W-1:0]   bcap_r, bcap_nxt;
  logic [START_W-1:0] bstart_r, bstart_nxt;
  logic [CAP_W-1:0]   iused_r, iused_nxt;
  logic [CAP_W-1:0]   bused_r, bused_nxt;

  // Sequencer
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic               op_r, op_nxt;
  logic               kind_r, kind_nxt;
  status_t            status_r, status_nxt;
  logic [NUM_W-1:0]   got_r, got_nxt;
  logic [ROW_W-1:0]   scan_w_r, scan_w_nxt;
  logic [ROW_W-1:0]   chk_w_r, chk_w_nxt;
  logic [ROW_W-1:0]   start_w_r, start_w_nxt;
  logic [ROW_W-1:0]   last_w_r, last_w_nxt;
  logic [WORD_W-1:0]  bit_off_r, bit_off_nxt;
  logic [SCAN_WORD_BITS-1:0] lo_mask_r, lo_mask_nxt;
  logic [SCAN_WORD_BITS-1:0] hi_mask_r, hi_mask_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Map memory
  ram_req_t                  ram_req;
  logic [SCAN_WORD_BITS-1:0] ram_wdata;
  logic [SCAN_WORD_BITS-1:0] ram_rdata;

  // Request decode
  logic               in_op;
  logic               in_kind;
  logic [NUM_W-1:0]   in_number;
  logic [CAP_W-1:0]   sel_cap;
  logic [BIT_W-1:0]   sel_start;
  logic [BIT_W-1:0]   last_idx;
  logic [BIT_W-1:0]   free_idx;
  logic               start_past_cap;
  logic               num_bad;

  // Scan datapath
  logic [SCAN_WORD_BITS-1:0] scan_word;
  logic                      scan_hit;
  logic [WORD_W-1:0]         scan_pos;

  // Result
  logic [CAP_W-1:0] rsp_cap;
  logic [CAP_W-1:0] rsp_used;
  logic [NUM_W-1:0] rsp_free;

  bffa_map_ram u_map_ram (
    .clk     (clk),
    .req     (ram_req),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  assign in_op     = in_tuser[0];
  assign in_kind   = in_tuser[1];
  assign in_number = in_tdata[NUM_W-1:0];

  assign sel_cap        = clamp_cap((in_kind == KIND_BLOCK) ? bcap_r : icap_r);
  assign sel_start      = (in_kind == KIND_BLOCK) ? BIT_W'(bstart_r) : '0;
  assign start_past_cap = CAP_W'(sel_start) >= sel_cap;
  assign last_idx       = BIT_W'(sel_cap - CAP_W'(1));
  assign num_bad        = (in_number == '0) || (CAP_W'(in_number) > sel_cap);
  assign free_idx       = BIT_W'(in_number - NUM_W'(1));

  // Force bits below the search start and at or above capacity to look taken.
  assign scan_word = ram_rdata
                   | ((chk_w_r == start_w_r) ? lo_mask_r : '0)
                   | ((chk_w_r == last_w_r) ? hi_mask_r : '0);
  assign scan_hit  = ~&scan_word;
  assign scan_pos  = first_zero(scan_word);

  assign rsp_cap  = clamp_cap((kind_r == KIND_BLOCK) ? bcap_r : icap_r);
  assign rsp_used = (kind_r == KIND_BLOCK) ? bused_r : iused_r;
  assign rsp_free = (rsp_used >= rsp_cap) ? '0 : NUM_W'(rsp_cap - rsp_used);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    icap_nxt      = icap_r;
    bcap_nxt      = bcap_r;
    bstart_nxt    = bstart_r;
    iused_nxt     = iused_r;
    bused_nxt     = bused_r;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    kind_nxt      = kind_r;
    status_nxt    = status_r;
    got_nxt       = got_r;
    scan_w_nxt    = scan_w_r;
    chk_w_nxt     = chk_w_r;
    start_w_nxt   = start_w_r;
    last_w_nxt    = last_w_r;
    bit_off_nxt   = bit_off_r;
    lo_mask_nxt   = lo_mask_r;
    hi_mask_nxt   = hi_mask_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_req       = '0;
    ram_wdata     = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_INODE_CAP:   icap_nxt   = cfg_wdata;
        CFG_BLOCK_CAP:   bcap_nxt   = cfg_wdata;
        CFG_BLOCK_START: bstart_nxt = cfg_wdata[START_W-1:0];
        default: ;
      endcase
    end

    // Drop the result once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        // Clear one map word per cycle after reset.
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = clr_r;
        clr_nxt         = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MEM_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_op;
          kind_nxt   = in_kind;
          got_nxt    = '0;
          status_nxt = ST_OK;
          if (in_op == OP_ALLOC) begin
            if (start_past_cap) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              scan_w_nxt  = sel_start[BIT_W-1:WORD_W];
              start_w_nxt = sel_start[BIT_W-1:WORD_W];
              last_w_nxt  = last_idx[BIT_W-1:WORD_W];
              lo_mask_nxt = ~({SCAN_WORD_BITS{1'b1}} << sel_start[WORD_W-1:0]);
              hi_mask_nxt = ({SCAN_WORD_BITS{1'b1}} << last_idx[WORD_W-1:0]) << 1;
              state_nxt   = S_FETCH;
            end
          end else begin
            if (num_bad) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESP;
            end else begin
              scan_w_nxt  = free_idx[BIT_W-1:WORD_W];
              bit_off_nxt = free_idx[WORD_W-1:0];
              state_nxt   = S_FETCH;
            end
          end
        end
      end

      S_FETCH: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = {kind_r, scan_w_r};
        chk_w_nxt       = scan_w_r;
        scan_w_nxt      = scan_w_r + ROW_W'(1);
        state_nxt       = (op_r == OP_FREE) ? S_FREE : S_SCAN;
      end

      S_SCAN: begin
        if (scan_hit) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = {kind_r, chk_w_r};
          ram_wdata       = ram_rdata | (SCAN_WORD_BITS'(1) << scan_pos);
          got_nxt         = NUM_W'({chk_w_r, scan_pos}) + NUM_W'(1);
          if (kind_r == KIND_BLOCK) begin
            bused_nxt = bused_r + CAP_W'(1);
          end else begin
            iused_nxt = iused_r + CAP_W'(1);
          end
          state_nxt = S_RESP;
        end else if (chk_w_r == last_w_r) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          // Read the next word while this one is checked.
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = {kind_r, scan_w_r};
          chk_w_nxt       = scan_w_r;
          scan_w_nxt      = scan_w_r + ROW_W'(1);
        end
      end

      S_FREE: begin
        if (!ram_rdata[bit_off_r]) begin
          status_nxt = ST_CLEAR;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = {kind_r, chk_w_r};
          ram_wdata       = ram_rdata & ~(SCAN_WORD_BITS'(1) << bit_off_r);
          if (kind_r == KIND_BLOCK) begin
            if (bused_r != '0) bused_nxt = bused_r - CAP_W'(1);
          end else begin
            if (iused_r != '0) iused_nxt = iused_r - CAP_W'(1);
          end
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({rsp_free, status_r, got_r});
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      icap_r      <= CAP_RESET;
      bcap_r      <= CAP_RESET;
      bstart_r    <= BLOCK_START_RESET;
      iused_r     <= '0;
      bused_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      icap_r      <= icap_nxt;
      bcap_r      <= bcap_nxt;
      bstart_r    <= bstart_nxt;
      iused_r     <= iused_nxt;
      bused_r     <= bused_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    kind_r     <= kind_nxt;
    status_r   <= status_nxt;
    got_r      <= got_nxt;
    scan_w_r   <= scan_w_nxt;
    chk_w_r    <= chk_w_nxt;
    start_w_r  <= start_w_nxt;
    last_w_r   <= last_w_nxt;
    bit_off_r  <= bit_off_nxt;
    lo_mask_r  <= lo_mask_nxt;
    hi_mask_r  <= hi_mask_nxt;
    out_data_r <= out_data_nxt;
  end

  // A failed or free request never reports an allocated number.
  a_num_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r[NUM_W+ST_W-1:NUM_W] != ST_OK) |-> out_data_r[NUM_W-1:0] == '0)
    else $error("allocated number set on a non-ok result");

  // Counts can never exceed the number of map bits.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (iused_r <= CAP_W'(MAP_BITS)) && (bused_r <= CAP_W'(MAP_BITS)))
    else $error("in-use count exceeds map size");

  // Map writes come only from the clearing pass or the scan or free steps.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> (state_r == S_INIT) || (state_r == S_SCAN) || (state_r == S_FREE))
    else $error("map written outside clear, scan or free");

  // An accepted item leaves in_tready low in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

endmodule

// ----- verif/alloc_result_checker.sv -----
`timescale 1ns / 100ps

module alloc_result_checker
  import bffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [13:0] number
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] op, [1] kind
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [13:0] allocated_number, [15:14] status,
                                            // [29:16] free_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CAP_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending_count,
  output int                    results_seen,
  output int                    full_seen,
  output int                    rejects_seen
);

  localparam int REPORT_LIMIT = 10;
  localparam int PAD_W        = OUT_DATA_W - 2 * NUM_W - ST_W;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    status_t          status;
    logic [NUM_W-1:0] free_cnt;
  } alloc_reply_t;

  // Own copy of both maps, their counts and the registers; index 0 is inodes, 1 blocks
  bit [MAP_BITS-1:0] taken [2];
  int                in_use [2];
  int                capacity [2];
  int                search_start;
  alloc_reply_t      expected_replies [$];

  // Apply one request to the maps and return the reply it must produce
  function automatic alloc_reply_t grant_or_release(logic op, logic kind,
                                                    logic [NUM_W-1:0] number);
    alloc_reply_t r;
    int           cap;
    int           first;
    bit           found;
    cap      = (capacity[kind] > MAP_BITS) ? MAP_BITS : capacity[kind];
    first    = (kind == KIND_BLOCK) ? search_start : 0;
    found    = 1'b0;
    r.number = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      r.status = ST_FULL;
      for (int i = first; i < cap && !found; i++) begin
        if (!taken[kind][i]) begin
          taken[kind][i] = 1'b1;
          in_use[kind]++;
          r.number = NUM_W'(i + 1);
          r.status = ST_OK;
          found    = 1'b1;
        end
      end
    end else if (number == 0 || number > cap) begin
      r.status = ST_RANGE;
    end else if (!taken[kind][number - 1]) begin
      r.status = ST_CLEAR;
    end else begin
      taken[kind][number - 1] = 1'b0;
      if (in_use[kind] > 0) in_use[kind]--;
    end
    r.free_cnt = (in_use[kind] >= cap) ? '0 : NUM_W'(cap - in_use[kind]);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    alloc_reply_t     want;
    logic [NUM_W-1:0] got_num;
    logic [NUM_W-1:0] got_free;
    logic [ST_W-1:0]  got_st;
    logic [PAD_W-1:0] got_pad;
    if (!rst_n) begin
      taken[0]     = '0;
      taken[1]     = '0;
      in_use[0]    = 0;
      in_use[1]    = 0;
      capacity[0]  = CAP_RESET;
      capacity[1]  = CAP_RESET;
      search_start = BLOCK_START_RESET;
      expected_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INODE_CAP:   capacity[0]  = cfg_wdata;
          CFG_BLOCK_CAP:   capacity[1]  = cfg_wdata;
          CFG_BLOCK_START: search_start = cfg_wdata[START_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_replies.push_back(grant_or_release(in_tuser[0], in_tuser[1],
                                                    in_tdata[NUM_W-1:0]));
      if (out_tvalid && out_tready) begin
        {got_pad, got_free, got_st, got_num} = out_tdata;
        results_seen++;
        if (expected_replies.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: reply with no request outstanding: number %0d status %0d free %0d",
                     $time, got_num, got_st, got_free);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_RANGE || want.status == ST_CLEAR) rejects_seen++;
          if (got_num !== want.number || got_st !== want.status ||
              got_free !== want.free_cnt || got_pad !== '0) begin
            if (fail_count < REPORT_LIMIT) begin
              $write("%0t: reply mismatch: expected number %0d status %0d free %0d,",
                     $time, want.number, want.status, want.free_cnt);
              $display(" got number %0d status %0d free %0d pad %0h",
                       got_num, got_st, got_free, got_pad);
            end
            fail_count++;
          end
        end
      end
    end
    pending_count <= expected_replies.size();
  end

endmodule

// ----- verif/tb_bitmap_first_free_allocator.sv -----
`timescale 1ns / 100ps

module tb_bitmap_first_free_allocator;
  import bffa_pkg::*;

  localparam int CLK_HALF         = 5;
  // Watchdog limit; a correct run stays well under it
  localparam int CYCLE_LIMIT      = 2_000_000;
  // Longest request is a full 256-word scan; the tail wait covers it
  localparam int TAIL_CYCLES      = 300;
  // Every request answers, so a few cycles cover the block's return to idle
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 500;
  // Index 3 maps to no register; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_INODE_CAP;
  logic [CAP_W-1:0]      cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending_count;
  int results_seen;
  int full_seen;
  int rejects_seen;

  int cycle_count     = 0;
  int items_sent      = 0;
  int settings_used   = 0;
  int long_holds_asked = 0;
  int long_holds_done  = 0;
  bit sender_eager     = 1'b0;

  // Register values as last written, used to aim free numbers at live entries
  int inode_cap_now;
  int block_cap_now;
  int start_now;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  bitmap_first_free_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  alloc_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .results_seen  (results_seen),
    .full_seen     (full_seen),
    .rejects_seen  (rejects_seen)
  );

  // Watchdog: abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bitmap_first_free_allocator: FAIL");
      $finish;
    end
  end

  // Result side: random stalls, mostly short, some long, with runs of steady
  // acceptance; on request hold off for a long stretch so the block backs up
  initial begin : result_sink
    int roll;
    int stall;
    wait (rst_n);
    forever begin
      if (long_holds_asked != long_holds_done) begin
        long_holds_done++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55)      stall = 0;
        else if (roll < 90) stall = $urandom_range(1, 3);
        else                stall = $urandom_range(15, 60);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
        else                           repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until the block takes it
  task automatic send_item(input logic op, input logic kind, input logic [NUM_W-1:0] number);
    in_tvalid <= 1'b1;
    in_tuser  <= {kind, op};
    in_tdata  <= {{(IN_DATA_W - NUM_W){1'b0}}, number};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Drop valid for a random gap between items, unless the sender is pushing hard
  task automatic idle_gap();
    int roll;
    int gap;
    if (sender_eager) return;
    roll = $urandom_range(0, 99);
    if (roll < 60)      gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else                gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every reply is back and the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CAP_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_INODE_CAP:   inode_cap_now = value & 'h3FFF;
      CFG_BLOCK_CAP:   block_cap_now = value & 'h3FFF;
      CFG_BLOCK_START: start_now     = value & 'h1FFF;
      default: ;
    endcase
  endtask

  // Reprogram all three registers once the block has gone quiet, optionally writing the spare index
  task automatic apply_settings(input int inode_cap, input int block_cap, input int start,
                                input bit poke_spare);
    drain();
    write_reg(CFG_INODE_CAP, inode_cap);
    write_reg(CFG_BLOCK_CAP, block_cap);
    write_reg(CFG_BLOCK_START, start);
    if (poke_spare) write_reg(CFG_SPARE, 'h3FFF);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random request; frees aim mostly at the region where first fit places entries,
  // with zero, the capacity edge and fully random numbers mixed in
  task automatic random_item(input int alloc_pct);
    logic             op;
    logic             kind;
    logic [NUM_W-1:0] number;
    int               cap;
    int               lo;
    int               hi;
    int               pick;
    kind   = 1'($urandom_range(0, 1));
    op     = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
    cap    = (kind == KIND_BLOCK) ? block_cap_now : inode_cap_now;
    if (cap > MAP_BITS) cap = MAP_BITS;
    number = NUM_W'($urandom);
    if (op == OP_FREE) begin
      pick = $urandom_range(0, 99);
      lo   = ((kind == KIND_BLOCK) ? start_now : 0) + 1;
      hi   = (lo + 95 > cap) ? cap : lo + 95;
      if (lo > hi) lo = 1;
      if (pick < 70 && cap > 0) number = NUM_W'($urandom_range(lo, hi));
      else if (pick < 78)       number = 0;
      else if (pick < 90)       number = NUM_W'(cap + $urandom_range(0, 2));
    end
    send_item(op, kind, number);
    idle_gap();
  endtask

  task automatic run_phase(input int count, input int alloc_pct);
    repeat (count) random_item(alloc_pct);
  endtask

  initial begin : stimulus
    int ic;
    int bc;
    int st;
    repeat (2) @(posedge clk);
    rst_n         <= 1'b1;
    inode_cap_now = CAP_RESET;
    block_cap_now = CAP_RESET;
    start_now     = BLOCK_START_RESET;
    @(posedge clk);

    // Directed pass on reset settings: first fit from bit 0 and from the block start,
    // reuse of the lowest freed entry, out-of-range and already-free frees
    send_item(OP_ALLOC, KIND_INODE, '0);
    send_item(OP_ALLOC, KIND_INODE, '0);
    send_item(OP_ALLOC, KIND_BLOCK, '0);
    send_item(OP_ALLOC, KIND_BLOCK, '0);
    send_item(OP_FREE,  KIND_INODE, 14'd0);
    send_item(OP_FREE,  KIND_INODE, 14'd8192);
    send_item(OP_FREE,  KIND_INODE, 14'd8193);
    send_item(OP_FREE,  KIND_BLOCK, 14'h3FFF);
    send_item(OP_FREE,  KIND_INODE, 14'd1);
    send_item(OP_FREE,  KIND_INODE, 14'd1);
    send_item(OP_ALLOC, KIND_INODE, '0);
    send_item(OP_FREE,  KIND_BLOCK, 14'd11);
    send_item(OP_FREE,  KIND_BLOCK, 14'd10);
    send_item(OP_ALLOC, KIND_BLOCK, 14'h3FFF);
    send_item(OP_ALLOC, KIND_INODE, 14'h3FFF);
    send_item(OP_FREE,  KIND_BLOCK, 14'd12);
    send_item(OP_FREE,  KIND_BLOCK, 14'd1);
    send_item(OP_FREE,  KIND_INODE, 14'd3);

    // Small maps, filled past full
    apply_settings(40, 48, 0, 1'b0);
    run_phase(150, 60);

    // Oversized capacity saturates; block search starts on the last bit; spare index
    apply_settings('h3FFF, 8192, 8191, 1'b1);
    long_holds_asked++;
    run_phase(120, 50);

    // Zero capacity: every allocate is full, every free out of range
    apply_settings(0, 0, 5, 1'b0);
    run_phase(60, 50);

    apply_settings(1, 1, 0, 1'b0);
    run_phase(80, 50);

    // Capacity below entries still set; start written with its top bit set gets masked
    apply_settings(24, 20, 'h2005, 1'b0);
    run_phase(150, 50);

    // Back-to-back requests into a long result hold-off
    apply_settings(8192, 8192, 10, 1'b0);
    sender_eager = 1'b1;
    long_holds_asked++;
    run_phase(200, 65);
    sender_eager = 1'b0;

    apply_settings(100, 300, 200, 1'b0);
    run_phase(200, 55);

    // Random settings, search start sometimes past the block capacity
    repeat (3) begin
      ic = $urandom_range(1, 128);
      bc = $urandom_range(1, 160);
      st = $urandom_range(0, bc + 4);
      apply_settings(ic, bc, st, 1'b0);
      run_phase(150, 55);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests under %0d register settings after the reset defaults;",
             items_sent, settings_used);
    $display("%0d replies checked, %0d with a full map, %0d rejected frees.",
             results_seen, full_seen, rejects_seen);
    if (fail_count == 0) begin
      $display("tb_bitmap_first_free_allocator: PASS");
    end else begin
      $display("tb_bitmap_first_free_allocator: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bffa_pkg.sv
rtl/bffa_map_ram.sv
rtl/bitmap_first_free_allocator.sv
verif/alloc_result_checker.sv
verif/tb_bitmap_first_free_allocator.sv
